[hdl/cmur_pkg.sv]
// shared types, constants and helpers for the clipmap update-region splitter
package cmur_pkg;

    // internal coordinate width: a 16-bit corner plus a window side of up to 2^15
    localparam int CW = 18;

    localparam int SIZE_LOG2_W = 4;
    localparam logic [SIZE_LOG2_W-1:0] SIZE_LOG2_RESET = 4'd9;
    localparam logic [SIZE_LOG2_W-1:0] MIN_SIZE_LOG2   = 4'd4;

    typedef logic signed [CW-1:0] coord_t;

    // one axis of a rectangle, with its optional cut at a grid line
    typedef struct packed {
        coord_t lo;
        coord_t mid;
        coord_t hi;
        logic   split;
    } seg_t;

    typedef struct packed {
        seg_t x;
        seg_t y;
    } box_t;

    typedef struct packed {
        logic still;
        logic two;
        box_t a;
        box_t b;
    } plan_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [12:0] w;
        logic [12:0] h;
        logic        nothing;
        logic        last;
    } piece_t;

    function automatic seg_t make_seg(coord_t lo, coord_t hi, coord_t mask);
        seg_t   sg;
        coord_t glo;
        coord_t ghi;
        glo      = lo & ~mask;
        ghi      = hi & ~mask;
        sg.lo    = lo;
        sg.hi    = hi;
        sg.mid   = ghi;
        sg.split = (glo != ghi) && (hi != ghi);
        return sg;
    endfunction

endpackage

[hdl/clipmap_update_region_split_core.sv]
// top level of the clipmap update-region splitter
//
// Input channel s_*: one beat carries the old and new top-left corners of the
// clipmap window. Output channel m_*: one beat per rectangle of newly exposed
// texels, with m_last on the final rectangle of that move. An unmoved window
// gives one beat with m_nothing_needed set and all rectangle fields zero.
// cfg_wr_en/cfg_wr_data write size_log2 (window side 2^size_log2, reset 9);
// write it only while no move is in flight.
// A move passes the input register, the rectangle walker and the output
// register before its first rectangle is shown. It gives one to eight
// rectangles, one rectangle per cycle while m_ready is high; the output
// register is the limit. Input register, walker and output register each
// hold one stage, so the next move is taken while the current one drains.
// When m_ready is low the output beat holds, the walker stops, and s_ready
// drops once the input register is also full.
// Reset (aresetn low, synchronous) empties every stage and sets size_log2 to 9.
module clipmap_update_region_split_core #(
    parameter int MAX_SIZE_LOG2 = 12
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [cmur_pkg::SIZE_LOG2_W-1:0] cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [15:0]               s_old_x,
    input  logic signed [15:0]               s_old_y,
    input  logic signed [15:0]               s_new_x,
    input  logic signed [15:0]               s_new_y,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [15:0]               m_rect_x,
    output logic signed [15:0]               m_rect_y,
    output logic [12:0]                      m_rect_w,
    output logic [12:0]                      m_rect_h,
    output logic                             m_nothing_needed,
    output logic                             m_last
);
    import cmur_pkg::*;

    logic [SIZE_LOG2_W-1:0] size_log2_reg;
    logic                   in_valid_reg;
    logic signed [15:0]     old_x_reg, old_y_reg, new_x_reg, new_y_reg;
    logic                   out_valid_reg;
    piece_t                 out_reg;

    plan_t  plan;
    piece_t piece;
    logic   list_valid, list_final;
    logic   out_load, list_free, list_load;

    assign out_load  = list_valid && (!out_valid_reg || m_ready);
    assign list_free = !list_valid || (out_load && list_final);
    assign list_load = in_valid_reg && list_free;
    assign s_ready   = !in_valid_reg || list_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_log2_reg <= SIZE_LOG2_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                size_log2_reg <= cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (list_load) begin
                in_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            old_x_reg <= s_old_x;
            old_y_reg <= s_old_y;
            new_x_reg <= s_new_x;
            new_y_reg <= s_new_y;
        end
        if (out_load) begin
            out_reg <= piece;
        end
    end

    cmur_plan #(
        .MAX_SIZE_LOG2 (MAX_SIZE_LOG2)
    ) u_plan (
        .size_log2 (size_log2_reg),
        .old_x     (old_x_reg),
        .old_y     (old_y_reg),
        .new_x     (new_x_reg),
        .new_y     (new_y_reg),
        .plan      (plan)
    );

    cmur_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (list_load),
        .plan_in     (plan),
        .take        (out_load),
        .valid       (list_valid),
        .piece       (piece),
        .final_piece (list_final)
    );

    assign m_valid          = out_valid_reg;
    assign m_rect_x         = out_reg.x;
    assign m_rect_y         = out_reg.y;
    assign m_rect_w         = out_reg.w;
    assign m_rect_h         = out_reg.h;
    assign m_nothing_needed = out_reg.nothing;
    assign m_last           = out_reg.last;

endmodule

[hdl/cmur_plan.sv]
// works out the one or two exposed rectangles and their grid cuts for one move
module cmur_plan #(
    parameter int MAX_SIZE_LOG2 = 12
) (
    input  logic [cmur_pkg::SIZE_LOG2_W-1:0] size_log2,
    input  logic signed [15:0]               old_x,
    input  logic signed [15:0]               old_y,
    input  logic signed [15:0]               new_x,
    input  logic signed [15:0]               new_y,
    output cmur_pkg::plan_t                  plan
);
    import cmur_pkg::*;

    logic [SIZE_LOG2_W-1:0] lg;
    coord_t s, mask;
    coord_t ox, oy, nx, ny;
    coord_t oxs, oys, nxs, nys;
    coord_t dx, dy, adx, ady;
    logic   far;
    seg_t   x_full, y_full, x_strip, y_strip, x_rest;

    always_comb begin
        if (size_log2 < MIN_SIZE_LOG2) begin
            lg = MIN_SIZE_LOG2;
        end else if (size_log2 > SIZE_LOG2_W'(MAX_SIZE_LOG2)) begin
            lg = SIZE_LOG2_W'(MAX_SIZE_LOG2);
        end else begin
            lg = size_log2;
        end
        s    = CW'(1) << lg;
        mask = s - CW'(1);

        ox  = CW'(old_x);
        oy  = CW'(old_y);
        nx  = CW'(new_x);
        ny  = CW'(new_y);
        oxs = ox + s;
        oys = oy + s;
        nxs = nx + s;
        nys = ny + s;

        dx  = nx - ox;
        dy  = ny - oy;
        adx = dx[CW-1] ? -dx : dx;
        ady = dy[CW-1] ? -dy : dy;
        far = (adx >= s) || (ady >= s);

        // every edge is one of the old or new corners, with or without the side added
        x_full  = make_seg(nx, nxs, mask);
        y_full  = make_seg(ny, nys, mask);
        x_strip = dx[CW-1] ? make_seg(nx, ox, mask) : make_seg(oxs, nxs, mask);
        y_strip = dy[CW-1] ? make_seg(ny, oy, mask) : make_seg(oys, nys, mask);
        x_rest  = dx[CW-1] ? make_seg(ox, nxs, mask) : make_seg(nx, oxs, mask);

        plan.still = (dx == '0) && (dy == '0);
        plan.two   = !far && (dx != '0) && (dy != '0);

        if (far) begin
            plan.a.x = x_full;
            plan.a.y = y_full;
        end else if (dx == '0) begin
            plan.a.x = x_full;
            plan.a.y = y_strip;
        end else begin
            plan.a.x = x_strip;
            plan.a.y = y_full;
        end
        // second leg of the L
        plan.b.x = x_rest;
        plan.b.y = y_strip;
    end

endmodule

[hdl/cmur_seq.sv]
// holds one plan and walks its pieces out one per beat
module cmur_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  cmur_pkg::plan_t  plan_in,
    input  logic             take,
    output logic             valid,
    output cmur_pkg::piece_t piece,
    output logic             final_piece
);
    import cmur_pkg::*;

    plan_t  plan_reg;
    logic   valid_reg, valid_next;
    logic   r_reg, r_next;
    logic   xi_reg, xi_next;
    logic   yi_reg, yi_next;
    box_t   cur;
    coord_t sx, ex, sy, ey, lx, ly;

    always_ff @(posedge aclk) begin
        if (load) begin
            plan_reg <= plan_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            r_reg     <= 1'b0;
            xi_reg    <= 1'b0;
            yi_reg    <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            r_reg     <= r_next;
            xi_reg    <= xi_next;
            yi_reg    <= yi_next;
        end
    end

    always_comb begin
        cur = r_reg ? plan_reg.b : plan_reg.a;

        final_piece = plan_reg.still ||
                      ((!cur.y.split || yi_reg) && (!cur.x.split || xi_reg) &&
                       (r_reg || !plan_reg.two));

        // y pieces run fastest, then x pieces, then the second rectangle
        r_next  = r_reg;
        xi_next = xi_reg;
        yi_next = yi_reg;
        if (load) begin
            r_next  = 1'b0;
            xi_next = 1'b0;
            yi_next = 1'b0;
        end else if (take) begin
            if (cur.y.split && !yi_reg) begin
                yi_next = 1'b1;
            end else begin
                yi_next = 1'b0;
                if (cur.x.split && !xi_reg) begin
                    xi_next = 1'b1;
                end else begin
                    xi_next = 1'b0;
                    r_next  = 1'b1;
                end
            end
        end

        if (load) begin
            valid_next = 1'b1;
        end else if (take && final_piece) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_comb begin
        sx = xi_reg ? cur.x.mid : cur.x.lo;
        ex = (cur.x.split && !xi_reg) ? cur.x.mid : cur.x.hi;
        sy = yi_reg ? cur.y.mid : cur.y.lo;
        ey = (cur.y.split && !yi_reg) ? cur.y.mid : cur.y.hi;
        lx = ex - sx;
        ly = ey - sy;

        if (plan_reg.still) begin
            piece.x = '0;
            piece.y = '0;
            piece.w = '0;
            piece.h = '0;
        end else begin
            piece.x = sx[15:0];
            piece.y = sy[15:0];
            piece.w = lx[12:0];
            piece.h = ly[12:0];
        end
        piece.nothing = plan_reg.still;
        piece.last    = final_piece;
    end

    assign valid = valid_reg;

endmodule

[hdl/cmur_check.sv]
// port-level checks for the clipmap update-region splitter, bound to the top level
module cmur_check (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_rect_x,
    input logic signed [15:0] m_rect_y,
    input logic [12:0]        m_rect_w,
    input logic [12:0]        m_rect_h,
    input logic               m_nothing_needed,
    input logic               m_last
);

    // output stages come up empty
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat shown right after reset");

    // an unmoved window is a single beat
    a_nothing_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_nothing_needed |-> m_last)
        else $error("nothing_needed beat without last");

    a_nothing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_nothing_needed |->
            m_rect_x == 16'sd0 && m_rect_y == 16'sd0 &&
            m_rect_w == 13'd0 && m_rect_h == 13'd0)
        else $error("nothing_needed beat with nonzero rectangle");

    // stalled result beat must hold
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=>
            m_valid && $stable(m_rect_x) && $stable(m_rect_y) && $stable(m_rect_w) &&
            $stable(m_rect_h) && $stable(m_nothing_needed) && $stable(m_last))
        else $error("result beat changed while stalled");

endmodule

bind clipmap_update_region_split_core cmur_check u_cmur_check (.*);
